@@ rtl/q8bsd_pkg.sv @@
// ----------------------------------------------------------------------------
// q8bsd_pkg
// shared types, constants and float helpers of the q8 block scaled dot unit
// ----------------------------------------------------------------------------
package q8bsd_pkg;

   localparam int unsigned BLOCK_ELEMS_DEF = 32;
   localparam logic [31:0] QNAN            = 32'h7FC0_0000;
   localparam logic [7:0]  EXP_MAX         = 8'hFF;
   // exponent that makes an integer mantissa read as its own value
   localparam logic [8:0]  INT_EXP         = 9'd150;

   // unpacked single precision operand
   typedef struct packed {
      logic        sign;
      logic        nan;
      logic        inf;
      logic        zero;
      logic [8:0]  exp;
      logic [23:0] mant;
   } fp_unpk_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic take_last;
      logic issue_scale;
      logic issue_prod;
      logic cap_scale;
      logic load_out;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mul_done;
      logic out_free;
   } dp_stat_type;

   function automatic fp_unpk_type unpack_bits(input logic [31:0] b);
      fp_unpk_type u;
      u.sign = b[31];
      u.nan  = (b[30:23] == EXP_MAX) && (b[22:0] != '0);
      u.inf  = (b[30:23] == EXP_MAX) && (b[22:0] == '0);
      u.zero = (b[30:23] == '0) && (b[22:0] == '0);
      u.exp  = (b[30:23] == '0) ? 9'd1 : {1'b0, b[30:23]};
      u.mant = {(b[30:23] != '0), b[22:0]};
      return u;
   endfunction

endpackage

@@ rtl/q8bsd_fmul.sv @@
// ----------------------------------------------------------------------------
// q8bsd_fmul
// three stage single precision multiplier, round to nearest even, subnormals
// ----------------------------------------------------------------------------
module q8bsd_fmul (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  q8bsd_pkg::fp_unpk_type op_a,
   input  q8bsd_pkg::fp_unpk_type op_b,
   output logic                   out_valid,
   output logic [31:0]            result
);
   import q8bsd_pkg::*;

   logic              v1_ff, v2_ff, v3_ff;
   // stage 1: product
   logic              s1_sign_ff, s1_nan_ff, s1_inf_ff, s1_zero_ff;
   logic [47:0]       s1_prod_ff;
   logic [9:0]        s1_esum_ff;
   // stage 2: normalized
   logic              s2_sign_ff, s2_nan_ff, s2_inf_ff, s2_zero_ff;
   logic [47:0]       s2_norm_ff;
   logic signed [10:0] s2_exp_ff;
   logic [31:0]       s3_res_ff;

   logic [5:0]         lz;
   logic [47:0]        norm_in;
   logic signed [10:0] exp_in;

   always_comb begin
      lz = '0;
      for (int i = 0; i < 48; i++) begin
         if (s1_prod_ff[i]) lz = 6'(47 - i);
      end
      norm_in = s1_prod_ff << lz;
      exp_in  = $signed({1'b0, s1_esum_ff}) - $signed({5'b0, lz}) - 11'sd126;
   end

   logic [5:0]  rsh;
   logic [47:0] shifted, lost_mask;
   logic [11:0] exp_field;
   logic [23:0] mant24;
   logic        guard, sticky, rnd;
   logic [34:0] total;
   logic [31:0] res_in;

   always_comb begin
      if (s2_exp_ff >= 11'sd1) begin
         rsh       = '0;
         exp_field = 12'(s2_exp_ff - 11'sd1);
      end else begin
         rsh       = (s2_exp_ff < -11'sd47) ? 6'd49 : 6'(11'sd1 - s2_exp_ff);
         exp_field = '0;
      end
      shifted   = s2_norm_ff >> rsh;
      lost_mask = ~({48{1'b1}} << rsh);
      mant24    = shifted[47:24];
      guard     = shifted[23];
      sticky    = (|shifted[22:0]) | (|(s2_norm_ff & lost_mask));
      rnd       = guard & (sticky | mant24[0]);
      total     = {exp_field, 23'b0} + {11'b0, mant24} + {34'b0, rnd};
      if (s2_nan_ff)
         res_in = QNAN;
      else if (s2_inf_ff || (total[34:23] >= 12'd255))
         res_in = {s2_sign_ff, EXP_MAX, 23'b0};
      else if (s2_zero_ff)
         res_in = {s2_sign_ff, 31'b0};
      else
         res_in = {s2_sign_ff, total[30:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (in_valid) begin
         s1_sign_ff <= op_a.sign ^ op_b.sign;
         s1_nan_ff  <= op_a.nan | op_b.nan | (op_a.inf & op_b.zero) | (op_a.zero & op_b.inf);
         s1_inf_ff  <= op_a.inf | op_b.inf;
         s1_zero_ff <= op_a.zero | op_b.zero;
         s1_prod_ff <= op_a.mant * op_b.mant;
         s1_esum_ff <= {1'b0, op_a.exp} + {1'b0, op_b.exp};
      end
      if (v1_ff) begin
         s2_sign_ff <= s1_sign_ff;
         s2_nan_ff  <= s1_nan_ff;
         s2_inf_ff  <= s1_inf_ff;
         s2_zero_ff <= s1_zero_ff;
         s2_norm_ff <= norm_in;
         s2_exp_ff  <= exp_in;
      end
      if (v2_ff) s3_res_ff <= res_in;
   end

   assign out_valid = v3_ff;
   assign result    = s3_res_ff;

endmodule

@@ rtl/q8bsd_datapath.sv @@
// ----------------------------------------------------------------------------
// q8bsd_datapath
// product accumulator, scale capture, float multiplier and result register
// ----------------------------------------------------------------------------
module q8bsd_datapath #(
   parameter int unsigned BLOCK_ELEMS = q8bsd_pkg::BLOCK_ELEMS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  q8bsd_pkg::dp_cmd_type cmd,
   output q8bsd_pkg::dp_stat_type stat,
   input  logic signed [7:0]     w_quant,
   input  logic signed [7:0]     a_quant,
   input  logic [31:0]           w_scale,
   input  logic [31:0]           a_scale,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_dot_result
);
   import q8bsd_pkg::*;

   localparam int unsigned SUM_W = 16 + $clog2(BLOCK_ELEMS);

   logic signed [SUM_W-1:0] sum_ff;
   logic [31:0]             w_scale_ff, a_scale_ff, scale_ff, out_ff;
   logic                    out_valid_ff;

   logic signed [15:0]      prod;
   logic [SUM_W-1:0]        mag;
   fp_unpk_type             op_a, op_b, sum_op;
   logic                    mul_valid;
   logic [31:0]             mul_res;

   assign prod = w_quant * a_quant;
   assign mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   always_comb begin
      sum_op.sign = sum_ff[SUM_W-1];
      sum_op.nan  = 1'b0;
      sum_op.inf  = 1'b0;
      sum_op.zero = (sum_ff == '0);
      sum_op.exp  = INT_EXP;
      sum_op.mant = 24'(mag);
      op_a = cmd.issue_prod ? unpack_bits(scale_ff) : unpack_bits(w_scale_ff);
      op_b = cmd.issue_prod ? sum_op : unpack_bits(a_scale_ff);
   end

   q8bsd_fmul u_fmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmd.issue_scale | cmd.issue_prod),
      .op_a      (op_a),
      .op_b      (op_b),
      .out_valid (mul_valid),
      .result    (mul_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.take) sum_ff <= sum_ff + SUM_W'(prod);
         else if (cmd.issue_prod) sum_ff <= '0;
         if (cmd.load_out) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
      if (cmd.take_last) begin
         w_scale_ff <= w_scale;
         a_scale_ff <= a_scale;
      end
      if (cmd.cap_scale) scale_ff <= mul_res;
      if (cmd.load_out) out_ff <= mul_res;
   end

   assign stat.mul_done  = mul_valid;
   assign stat.out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid      = out_valid_ff;
   assign rsp_dot_result = out_ff;

endmodule

@@ rtl/q8bsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// q8bsd_ctrl
// element counter and sequencer of the two float multiplies
// ----------------------------------------------------------------------------
module q8bsd_ctrl #(
   parameter int unsigned BLOCK_ELEMS = q8bsd_pkg::BLOCK_ELEMS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output q8bsd_pkg::dp_cmd_type  cmd,
   input  q8bsd_pkg::dp_stat_type stat
);
   import q8bsd_pkg::*;

   localparam int unsigned CNT_W = $clog2(BLOCK_ELEMS);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(BLOCK_ELEMS - 1);

   typedef enum logic [2:0] {
      ACC, ISSUE_S, WAIT_S, ISSUE_P, WAIT_P, DELIVER
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             ready_ff;

   always_comb begin
      cmd.take        = req_valid && ready_ff;
      cmd.take_last   = cmd.take && (cnt_ff == LAST);
      cmd.issue_scale = (state_ff == ISSUE_S);
      cmd.issue_prod  = (state_ff == ISSUE_P);
      cmd.cap_scale   = (state_ff == WAIT_S) && stat.mul_done;
      cmd.load_out    = (state_ff == DELIVER) && stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ACC;
         cnt_ff   <= '0;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ACC: begin
               if (cmd.take_last) begin
                  cnt_ff   <= '0;
                  ready_ff <= 1'b0;
                  state_ff <= ISSUE_S;
               end else if (cmd.take) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ISSUE_S: state_ff <= WAIT_S;
            WAIT_S:  if (stat.mul_done) state_ff <= ISSUE_P;
            ISSUE_P: state_ff <= WAIT_P;
            WAIT_P:  if (stat.mul_done) state_ff <= DELIVER;
            DELIVER: begin
               if (stat.out_free) begin
                  ready_ff <= 1'b1;
                  state_ff <= ACC;
               end
            end
            default: begin
               ready_ff <= 1'b1;
               state_ff <= ACC;
            end
         endcase
      end
   end

   assign req_ready = ready_ff;

   a_ready_only_acc: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> state_ff == ACC) else $error("ready outside accumulate");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.take_last |=> cnt_ff == '0 && !ready_ff) else $error("count not cleared");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      stat.mul_done |-> state_ff == WAIT_S || state_ff == WAIT_P)
      else $error("multiplier done outside wait");

endmodule

@@ rtl/q8_block_scaled_dot_unit.sv @@
// ----------------------------------------------------------------------------
// q8_block_scaled_dot_unit
// scaled dot product of blocks of signed 8-bit quant pairs
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per element, a weight and an activation quant;
//   the two float scales are sampled only with the last word of a block
//   rsp channel: one word per block, (w_scale*a_scale)*float(sum) as an
//   ieee single, both products rounded to nearest even, nan made canonical
//   non-last words leave req_ready high and give no rsp word
//   after the last word of a block req_ready is low during two passes
//   through the three stage float multiplier plus issue and hand-off,
//   and rises again once the result is loaded into the output register
//   the result sits in an output register; while the receiver stalls the
//   next block is still accumulated, and only a second finished result waits
//   reset clears the sum, the element count and the output valid
// ----------------------------------------------------------------------------
module q8_block_scaled_dot_unit #(
   parameter int unsigned BLOCK_ELEMS = q8bsd_pkg::BLOCK_ELEMS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic signed [7:0] req_w_quant,
   input  logic signed [7:0] req_a_quant,
   input  logic [31:0]       req_w_scale,
   input  logic [31:0]       req_a_scale,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_dot_result
);
   import q8bsd_pkg::*;

   // command and status between sequencer and datapath
   dp_cmd_type  cmd;
   dp_stat_type stat;

   q8bsd_ctrl #(.BLOCK_ELEMS(BLOCK_ELEMS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   q8bsd_datapath #(.BLOCK_ELEMS(BLOCK_ELEMS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .w_quant        (req_w_quant),
      .a_quant        (req_a_quant),
      .w_scale        (req_w_scale),
      .a_scale        (req_a_scale),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_dot_result (rsp_dot_result)
   );

endmodule
